### rtl/sfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants of the serial frame receiver
// Result kinds, config register indexes, reset values and the job record
// passed from the frame parser to the result sequencer.
// ----------------------------------------------------------------------------
package sfr_pkg;

	localparam int DATA_BYTES_DEF = 8;
	localparam int QUEUE_DEPTH    = 2;
	localparam int CFG_IDX_W      = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_HEADER  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FOOTER  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NOACK_A = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_NOACK_B = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_NOACK_C = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_NOACK_D = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_NOACK_E = 3'd6;

	localparam logic [7:0] HEADER_RST  = 8'hff;
	localparam logic [7:0] FOOTER_RST  = 8'hfe;
	localparam logic [7:0] NOACK_A_RST = 8'd1;
	localparam logic [7:0] NOACK_B_RST = 8'd2;
	localparam logic [7:0] NOACK_C_RST = 8'd3;
	localparam logic [7:0] NOACK_D_RST = 8'd4;
	localparam logic [7:0] NOACK_E_RST = 8'd5;

	typedef enum logic [2:0] {
		KIND_BAD_START    = 3'd0,
		KIND_BAD_END      = 3'd1,
		KIND_BAD_COUNTER  = 3'd2,
		KIND_BAD_CHECKSUM = 3'd3,
		KIND_ACK          = 3'd4,
		KIND_DATA         = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_ONE,
		B_CNT,
		B_SUM,
		B_ACK,
		B_DATA
	} back_state_t;

	typedef struct packed {
		logic [7:0] header;
		logic [7:0] footer;
		logic [7:0] noack_a;
		logic [7:0] noack_b;
		logic [7:0] noack_c;
		logic [7:0] noack_d;
		logic [7:0] noack_e;
	} sfr_cfg_t;

	typedef struct packed {
		logic       single;
		kind_t      single_kind;
		logic [7:0] seq_old;
		logic [7:0] seq_new;
		logic [7:0] got_seq;
		logic [7:0] chk_got;
		logic [7:0] chk_calc;
		logic       bad_cnt;
		logic       bad_sum;
		logic       do_ack;
		logic       do_data;
	} sfr_job_t;

endpackage

### rtl/sfr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_front: frame parser
// Tracks the byte position, collects counter, data and checksum bytes,
// keeps the expected counter and turns each event into a job record.
// ----------------------------------------------------------------------------
module sfr_front import sfr_pkg::*; #(
	parameter int DATA_BYTES = DATA_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sfr_cfg_t                    cfg,
	input  logic                        take,
	input  logic [7:0]                  rx_byte,
	output logic                        push,
	output sfr_job_t                    job,
	output logic [DATA_BYTES-1:0][7:0]  job_data
);

	localparam int FRAME_LEN = DATA_BYTES + 4;
	localparam int POS_W     = $clog2(FRAME_LEN);
	localparam logic [POS_W-1:0] POS_HEAD  = POS_W'(0);
	localparam logic [POS_W-1:0] POS_CNT   = POS_W'(1);
	localparam logic [POS_W-1:0] POS_CHECK = POS_W'(DATA_BYTES + 2);
	localparam logic [POS_W-1:0] POS_FOOT  = POS_W'(DATA_BYTES + 3);

	logic [POS_W-1:0]           pos_q;
	logic [7:0]                 exp_q;
	logic                       bad_start_q;
	logic                       ferr_q;
	logic [7:0]                 got_seq_q;
	logic [7:0]                 sum_q;
	logic [7:0]                 chk_q;
	logic [DATA_BYTES-1:0][7:0] data_q;

	logic       bad_cnt;
	logic       bad_sum;
	logic       ok;
	logic       quiet;
	logic [7:0] seq_new;

	assign bad_cnt = got_seq_q != exp_q;
	assign bad_sum = sum_q != chk_q;
	assign ok      = !ferr_q && !bad_cnt && !bad_sum;
	assign seq_new = bad_cnt ? got_seq_q : exp_q;
	assign quiet   = (data_q[0] == cfg.noack_a) || (data_q[0] == cfg.noack_b) ||
	                 (data_q[0] == cfg.noack_c) || (data_q[0] == cfg.noack_d) ||
	                 (data_q[0] == cfg.noack_e);

	always_comb begin
		push             = 1'b0;
		job.single       = 1'b1;
		job.single_kind  = KIND_BAD_START;
		job.seq_old      = exp_q;
		job.seq_new      = exp_q;
		job.got_seq      = got_seq_q;
		job.chk_got      = chk_q;
		job.chk_calc     = sum_q;
		job.bad_cnt      = bad_cnt;
		job.bad_sum      = bad_sum;
		job.do_ack       = ok && !quiet;
		job.do_data      = ok;
		if (take && pos_q == POS_HEAD) begin
			push = (rx_byte != cfg.header) && !bad_start_q;
		end else if (take && pos_q == POS_FOOT) begin
			push = 1'b1;
			if (rx_byte != cfg.footer) begin
				job.single_kind = KIND_BAD_END;
			end else begin
				job.single  = 1'b0;
				job.seq_new = seq_new;
			end
		end
	end

	assign job_data = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= POS_HEAD;
			exp_q       <= 8'd0;
			bad_start_q <= 1'b0;
			ferr_q      <= 1'b0;
		end else if (take) begin
			if (pos_q == POS_HEAD) begin
				if (rx_byte != cfg.header) begin
					bad_start_q <= 1'b1;
				end else begin
					bad_start_q <= 1'b0;
					pos_q       <= POS_CNT;
				end
			end else if (pos_q == POS_FOOT) begin
				pos_q <= POS_HEAD;
				if (rx_byte != cfg.footer) begin
					ferr_q <= 1'b1;
				end else begin
					ferr_q <= 1'b0;
					exp_q  <= seq_new + 8'd1;
				end
			end else begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (pos_q == POS_HEAD) begin
				sum_q <= 8'd0;
			end
			if (pos_q == POS_CNT) begin
				got_seq_q <= rx_byte;
			end
			if (pos_q == POS_CHECK) begin
				chk_q <= rx_byte;
			end
			for (int i = 0; i < DATA_BYTES; i++) begin
				if (pos_q == POS_W'(i + 2)) begin
					data_q[i] <= rx_byte;
					sum_q     <= sum_q ^ rx_byte;
				end
			end
		end
	end

endmodule

### rtl/sfr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_queue: job queue
// Short FIFO of job records and frame data between parser and sequencer.
// ----------------------------------------------------------------------------
module sfr_queue import sfr_pkg::*; #(
	parameter int DATA_BYTES = DATA_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  sfr_job_t                    job_in,
	input  logic [DATA_BYTES-1:0][7:0]  data_in,
	input  logic                        pop,
	output sfr_job_t                    job_out,
	output logic [DATA_BYTES-1:0][7:0]  data_out,
	output logic                        empty,
	output logic                        full
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	sfr_job_t                   job_mem [QUEUE_DEPTH];
	logic [DATA_BYTES-1:0][7:0] data_mem [QUEUE_DEPTH];
	logic [PTR_W-1:0]           wr_q;
	logic [PTR_W-1:0]           rd_q;
	logic [CNT_W-1:0]           cnt_q;

	assign empty    = cnt_q == CNT_W'(0);
	assign full     = cnt_q == CNT_W'(QUEUE_DEPTH);
	assign job_out  = job_mem[rd_q];
	assign data_out = data_mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			job_mem[wr_q]  <= job_in;
			data_mem[wr_q] <= data_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

### rtl/sfr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_back: result sequencer
// Expands the job at the queue head into result items, one per cycle while
// out_stall does not hold the output register, through an output register.
// ----------------------------------------------------------------------------
module sfr_back import sfr_pkg::*; #(
	parameter int DATA_BYTES = DATA_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sfr_job_t                    job,
	input  logic [DATA_BYTES-1:0][7:0]  job_data,
	input  logic                        empty,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [2:0]                  kind,
	output logic [7:0]                  expected_seq,
	output logic [7:0]                  value_got,
	output logic [7:0]                  value_calc,
	output logic                        last
);

	localparam int IDX_W = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DATA_BYTES - 1);

	back_state_t      state_q;
	back_state_t      state_d;
	back_state_t      first;
	back_state_t      nxt;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] idx_d;
	logic             load;
	logic             emit;

	logic             valid_q;
	logic [2:0]       kind_q;
	logic [7:0]       seq_q;
	logic [7:0]       got_q;
	logic [7:0]       calc_q;
	logic             last_q;

	kind_t            r_kind;
	logic [7:0]       r_seq;
	logic [7:0]       r_got;
	logic [7:0]       r_calc;

	assign load = !valid_q || !out_stall;

	always_comb begin
		first = B_IDLE;
		if (job.single) begin
			first = B_ONE;
		end else if (job.bad_cnt) begin
			first = B_CNT;
		end else if (job.bad_sum) begin
			first = B_SUM;
		end else if (job.do_ack) begin
			first = B_ACK;
		end else if (job.do_data) begin
			first = B_DATA;
		end

		nxt = B_IDLE;
		case (state_q)
			B_CNT:   nxt = job.bad_sum ? B_SUM : B_IDLE;
			B_ACK:   nxt = B_DATA;
			B_DATA:  nxt = (idx_q == IDX_LAST) ? B_IDLE : B_DATA;
			default: nxt = B_IDLE;
		endcase

		state_d = state_q;
		idx_d   = idx_q;
		pop     = 1'b0;
		emit    = 1'b0;
		case (state_q)
			B_IDLE: begin
				idx_d = '0;
				if (!empty) begin
					state_d = first;
					pop     = first == B_IDLE;
				end
			end
			default: begin
				if (load) begin
					emit    = 1'b1;
					state_d = nxt;
					pop     = nxt == B_IDLE;
					if (state_q == B_DATA) begin
						idx_d = idx_q + IDX_W'(1);
					end
				end
			end
		endcase
	end

	always_comb begin
		r_kind = KIND_DATA;
		r_seq  = job.seq_new;
		r_got  = 8'd0;
		r_calc = 8'd0;
		case (state_q)
			B_ONE:  r_kind = job.single_kind;
			B_CNT: begin
				r_kind = KIND_BAD_COUNTER;
				r_seq  = job.seq_old;
				r_got  = job.got_seq;
			end
			B_SUM: begin
				r_kind = KIND_BAD_CHECKSUM;
				r_got  = job.chk_got;
				r_calc = job.chk_calc;
			end
			B_ACK:  r_kind = KIND_ACK;
			B_DATA: r_got = job_data[idx_q];
			default: r_kind = KIND_DATA;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (load) begin
				valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q <= r_kind;
			seq_q  <= r_seq;
			got_q  <= r_got;
			calc_q <= r_calc;
			last_q <= nxt == B_IDLE;
		end
	end

	assign out_valid    = valid_q;
	assign kind         = kind_q;
	assign expected_seq = seq_q;
	assign value_got    = got_q;
	assign value_calc   = calc_q;
	assign last         = last_q;

endmodule

### rtl/serial_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_frame_receiver: serial byte deframer with XOR checksum
// Bytes enter at one per cycle while the two-entry job queue has room.
// A result item passes through the job queue, the sequencer state and the
// output register; a decoded frame end yields up to DATA_BYTES+1 results.
// Async active-low reset clears position, counters, flags and the queue and
// loads the config registers with their defaults.
// ----------------------------------------------------------------------------
module serial_frame_receiver import sfr_pkg::*; #(
	parameter int DATA_BYTES = DATA_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           rx_byte,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [2:0]           kind,
	output logic [7:0]           expected_seq,
	output logic [7:0]           value_got,
	output logic [7:0]           value_calc,
	output logic                 last
);

	sfr_cfg_t                   cfg_q;
	logic                       take;
	logic                       q_push;
	logic                       q_pop;
	logic                       q_empty;
	logic                       q_full;
	sfr_job_t                   f_job;
	sfr_job_t                   h_job;
	logic [DATA_BYTES-1:0][7:0] f_data;
	logic [DATA_BYTES-1:0][7:0] h_data;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_full;
	assign take      = in_valid && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header  <= HEADER_RST;
			cfg_q.footer  <= FOOTER_RST;
			cfg_q.noack_a <= NOACK_A_RST;
			cfg_q.noack_b <= NOACK_B_RST;
			cfg_q.noack_c <= NOACK_C_RST;
			cfg_q.noack_d <= NOACK_D_RST;
			cfg_q.noack_e <= NOACK_E_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_HEADER:  cfg_q.header  <= cfg_data;
				CFG_FOOTER:  cfg_q.footer  <= cfg_data;
				CFG_NOACK_A: cfg_q.noack_a <= cfg_data;
				CFG_NOACK_B: cfg_q.noack_b <= cfg_data;
				CFG_NOACK_C: cfg_q.noack_c <= cfg_data;
				CFG_NOACK_D: cfg_q.noack_d <= cfg_data;
				CFG_NOACK_E: cfg_q.noack_e <= cfg_data;
				default: ;
			endcase
		end
	end

	sfr_front #(.DATA_BYTES(DATA_BYTES)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.take     (take),
		.rx_byte  (rx_byte),
		.push     (q_push),
		.job      (f_job),
		.job_data (f_data)
	);

	sfr_queue #(.DATA_BYTES(DATA_BYTES)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.job_in   (f_job),
		.data_in  (f_data),
		.pop      (q_pop),
		.job_out  (h_job),
		.data_out (h_data),
		.empty    (q_empty),
		.full     (q_full)
	);

	sfr_back #(.DATA_BYTES(DATA_BYTES)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job          (h_job),
		.job_data     (h_data),
		.empty        (q_empty),
		.pop          (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.expected_seq (expected_seq),
		.value_got    (value_got),
		.value_calc   (value_calc),
		.last         (last)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("job queue overflow");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("job queue underflow");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_BAD_START || kind == KIND_BAD_END) |-> last)
		else $error("framing error item not marked last");

	a_ack_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_ACK |-> !last)
		else $error("ack item without data");

	a_calc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_BAD_CHECKSUM |-> value_calc == 8'd0)
		else $error("computed checksum on wrong item kind");

endmodule
